// ----- design/gfte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gfte_pkg
// Shared widths, register indexes, codes and state type of the grid edge store.
// ---------------------------------------------------------------------------
package gfte_pkg;

   localparam int MAX_SIDE_DEF = 64;   // default largest grid side
   localparam int MIN_SIDE     = 3;    // smallest grid side in use
   localparam int RESET_SIDE   = 64;   // size registers after reset

   localparam int CFG_W    = 7;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 6;
   localparam int CORNER_W = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

   localparam logic MODE_TOGGLE = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_FIRST  = 4'b0100,
      ST_SECOND = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// ----- design/gfte_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gfte_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gfte_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/grid_face_toggle_edge_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grid_face_toggle_edge_store
// Top/left edge bit store for a cell grid, with interior toggles and reports.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MAX_SIDE*MAX_SIDE
// entries (4096 at the default) of both edge memories, one entry a cycle;
// req_ready stays low until it ends, while size register writes are taken
// throughout. Then req_ready is high only in ST_IDLE: a report or rejected
// toggle goes through ST_FIRST, an accepted toggle through ST_FIRST and
// ST_SECOND; the last step loads the output register, and only then is a
// new item taken. Each edge memory has one read and one write port with
// registered read data, and a toggle needs two read-modify-writes on each
// memory. A new item is accepted while an earlier result still waits on
// rsp_ready; it then holds at its last step until the output register frees.
// ---------------------------------------------------------------------------
module grid_face_toggle_edge_store #(
   parameter int MAX_SIDE = gfte_pkg::MAX_SIDE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [gfte_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gfte_pkg::CFG_W-1:0]     csr_wdata,
   // request items
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_mode,
   input  wire logic [gfte_pkg::COL_W-1:0]     req_col,
   input  wire logic [gfte_pkg::ROW_W-1:0]     req_row,
   // result items
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_status,
   output      logic                           rsp_top_link,
   output      logic                           rsp_left_link,
   output      logic [gfte_pkg::CORNER_W-1:0]  rsp_corner_top_left,
   output      logic [gfte_pkg::CORNER_W-1:0]  rsp_corner_top_right,
   output      logic [gfte_pkg::CORNER_W-1:0]  rsp_corner_bottom_left
);

   import gfte_pkg::*;

   localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   // side values need room for MAX_SIDE, the raw register, and side + 1
   localparam int SIDE_W = (($clog2(MAX_SIDE + 1) > CFG_W) ?
                            $clog2(MAX_SIDE + 1) : CFG_W) + 1;
   localparam int CW     = ROW_W + SIDE_W + 1;

   // ------------------------------------------------------------------
   // Size registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] grid_width_ff, grid_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= CFG_W'(RESET_SIDE);
         grid_height_ff <= CFG_W'(RESET_SIDE);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            REG_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sides in use, clamped to MIN_SIDE..MAX_SIDE
   logic [SIDE_W-1:0] width_raw, height_raw, side_w, side_h;

   assign width_raw  = SIDE_W'(grid_width_ff);
   assign height_raw = SIDE_W'(grid_height_ff);

   always_comb begin
      if (width_raw < SIDE_W'(MIN_SIDE))       side_w = SIDE_W'(MIN_SIDE);
      else if (width_raw > SIDE_W'(MAX_SIDE))  side_w = SIDE_W'(MAX_SIDE);
      else                                     side_w = width_raw;
      if (height_raw < SIDE_W'(MIN_SIDE))      side_h = SIDE_W'(MIN_SIDE);
      else if (height_raw > SIDE_W'(MAX_SIDE)) side_h = SIDE_W'(MAX_SIDE);
      else                                     side_h = height_raw;
   end

   // ------------------------------------------------------------------
   // Request decode: range check and cell address
   // ------------------------------------------------------------------
   logic [SIDE_W-1:0] col_ext, row_ext;
   logic              toggle_ok, report_ok, req_ok;
   logic [31:0]       addr_full;
   logic [ADDR_W-1:0] req_addr;

   assign col_ext = SIDE_W'(req_col);
   assign row_ext = SIDE_W'(req_row);

   // interior cell: 1 <= col < w-1 and 1 <= row < h-1
   assign toggle_ok = (col_ext != '0) && (row_ext != '0) &&
                      ((col_ext + SIDE_W'(1)) < side_w) &&
                      ((row_ext + SIDE_W'(1)) < side_h);
   assign report_ok = (col_ext < side_w) && (row_ext < side_h);
   assign req_ok    = (req_mode == MODE_TOGGLE) ? toggle_ok : report_ok;

   // row*MAX_SIDE+col; an item in range always lands below CELL_COUNT
   assign addr_full = 32'(req_row) * 32'(MAX_SIDE) + 32'(req_col);
   assign req_addr  = addr_full[ADDR_W-1:0];

   // ------------------------------------------------------------------
   // Control state and captured item
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              mode_ff, ok_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_below, addr_right;
   logic              req_fire, out_free, is_toggle;
   logic              rsp_valid_ff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_toggle  = (mode_ff == MODE_TOGGLE) && ok_ff;
   assign addr_below = addr_ff + ADDR_W'(MAX_SIDE);
   assign addr_right = addr_ff + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_mode;
         ok_ff   <= req_ok;
         col_ff  <= req_col;
         row_ff  <= req_row;
         addr_ff <= req_addr;
      end
   end

   // ------------------------------------------------------------------
   // Edge memories
   // ------------------------------------------------------------------
   logic              top_we, left_we;
   logic [ADDR_W-1:0] top_wa, left_wa, top_ra, left_ra;
   logic              top_wd, left_wd, top_rd, left_rd;

   gfte_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_top_ram (
      .clock   (clock),
      .wr_en   (top_we),
      .wr_addr (top_wa),
      .wr_data (top_wd),
      .rd_addr (top_ra),
      .rd_data (top_rd)
   );

   gfte_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_left_ram (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (left_wa),
      .wr_data (left_wd),
      .rd_addr (left_ra),
      .rd_data (left_rd)
   );

   // ------------------------------------------------------------------
   // Corner indices on the (w+1)-wide point grid
   // ------------------------------------------------------------------
   logic [SIDE_W-1:0] point_w;
   logic [CW-1:0]     corner_tl, corner_tr, corner_bl;

   assign point_w   = side_w + SIDE_W'(1);
   assign corner_tl = CW'(row_ff) * CW'(point_w) + CW'(col_ff);
   assign corner_tr = corner_tl + CW'(1);
   assign corner_bl = corner_tl + CW'(point_w);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   logic                rsp_valid_in;
   logic                rsp_load;
   logic                res_status, res_top, res_left;
   logic [CORNER_W-1:0] res_tl, res_tr, res_bl;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      top_we   = 1'b0;
      left_we  = 1'b0;
      top_wa   = addr_ff;
      left_wa  = addr_ff;
      top_wd   = 1'b0;
      left_wd  = 1'b0;
      top_ra   = addr_ff;
      left_ra  = addr_ff;
      rsp_load   = 1'b0;
      res_status = STATUS_DONE;
      res_top    = 1'b0;
      res_left   = 1'b0;
      res_tl     = '0;
      res_tr     = '0;
      res_bl     = '0;

      case (state_ff)
         ST_CLEAR: begin
            top_we  = 1'b1;
            left_we = 1'b1;
            top_wa  = clr_ff;
            left_wa = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            top_ra  = req_addr;
            left_ra = req_addr;
            if (req_fire) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (is_toggle) begin
               // flip own edges, fetch the cell below and the cell to the right
               top_we   = 1'b1;
               left_we  = 1'b1;
               top_wd   = ~top_rd;
               left_wd  = ~left_rd;
               top_ra   = addr_below;
               left_ra  = addr_right;
               state_in = ST_SECOND;
            end else begin
               if (!ok_ff) begin
                  res_status = STATUS_REJECT;
               end else begin
                  res_top  = top_rd;
                  res_left = left_rd;
                  res_tl   = corner_tl[CORNER_W-1:0];
                  res_tr   = corner_tr[CORNER_W-1:0];
                  res_bl   = corner_bl[CORNER_W-1:0];
               end
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SECOND: begin
            top_ra  = addr_below;
            left_ra = addr_right;
            top_wa  = addr_below;
            left_wa = addr_right;
            top_wd  = ~top_rd;
            left_wd = ~left_rd;
            if (out_free) begin
               top_we   = 1'b1;
               left_we  = 1'b1;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic                status_ff, top_link_ff, left_link_ff;
   logic [CORNER_W-1:0] tl_ff, tr_ff, bl_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff    <= res_status;
         top_link_ff  <= res_top;
         left_link_ff <= res_left;
         tl_ff        <= res_tl;
         tr_ff        <= res_tr;
         bl_ff        <= res_bl;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_top_link           = top_link_ff;
   assign rsp_left_link          = left_link_ff;
   assign rsp_corner_top_left    = tl_ff;
   assign rsp_corner_top_right   = tr_ff;
   assign rsp_corner_bottom_left = bl_ff;

endmodule
`default_nettype wire

// ----- sim/grid_face_toggle_edge_store_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_face_toggle_edge_store_tb
// Self-checking bench: toggle and report items against a behavioural edge map.
// ---------------------------------------------------------------------------
// A short table of hand-picked items runs first at the reset grid size. Then
// random phases follow at a range of grid sizes, the clamped extremes among
// them. Every accepted item is run through a local predictor that keeps its
// own copy of both edge stores. Every result item is compared field by field
// with the oldest expected result. Sender and receiver both idle at random.
// ---------------------------------------------------------------------------
module grid_face_toggle_edge_store_tb;
   import gfte_pkg::*;

   localparam int SIDE            = MAX_SIDE_DEF;
   localparam int CELLS           = SIDE * SIDE;
   localparam int PROBE_ROWS      = 24;
   localparam int DRAIN_CYCLES    = 8;       // extra wait after the last result is taken
   localparam int LONG_HOLD       = 300;     // receiver hold-off, in cycles
   localparam int WATCHDOG_LIMIT  = 20000;   // covers the quiet clearing pass after reset

   typedef struct packed {
      logic                status;
      logic                top_link;
      logic                left_link;
      logic [CORNER_W-1:0] corner_top_left;
      logic [CORNER_W-1:0] corner_top_right;
      logic [CORNER_W-1:0] corner_bottom_left;
   } edge_report_type;

   // one row of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic             mode;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             typed;
      edge_report_type  want;
   } probe_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_GRID_WIDTH;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = MODE_REPORT;
   logic [COL_W-1:0]     req_col = '0;
   logic [ROW_W-1:0]     req_row = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_status;
   logic                 rsp_top_link;
   logic                 rsp_left_link;
   logic [CORNER_W-1:0]  rsp_corner_top_left;
   logic [CORNER_W-1:0]  rsp_corner_top_right;
   logic [CORNER_W-1:0]  rsp_corner_bottom_left;

   // travels alongside the item so the monitor knows whether a typed answer applies
   logic                 req_typed = 1'b0;
   edge_report_type      req_want = '0;

   // predictor state: its own edge maps and size registers
   bit                   top_edge_map  [CELLS];
   bit                   left_edge_map [CELLS];
   logic [CFG_W-1:0]     grid_width_q  = CFG_W'(RESET_SIDE);
   logic [CFG_W-1:0]     grid_height_q = CFG_W'(RESET_SIDE);

   // sizes last written by the stimulus, used to aim random items
   logic [CFG_W-1:0]     grid_width_set  = CFG_W'(RESET_SIDE);
   logic [CFG_W-1:0]     grid_height_set = CFG_W'(RESET_SIDE);

   edge_report_type      pending_reports[$];
   probe_row_type        probe_table [PROBE_ROWS];
   int                   mismatch_count = 0;
   int                   results_seen = 0;
   int                   idle_cycles = 0;
   int                   items_issued = 0;
   bit                   sender_calm = 1'b0;
   int                   rsp_holds_asked = 0;
   int                   rsp_holds_done = 0;

   grid_face_toggle_edge_store i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_col                (req_col),
      .req_row                (req_row),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_top_link           (rsp_top_link),
      .rsp_left_link          (rsp_left_link),
      .rsp_corner_top_left    (rsp_corner_top_left),
      .rsp_corner_top_right   (rsp_corner_top_right),
      .rsp_corner_bottom_left (rsp_corner_bottom_left)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // size registers are clamped to 3..SIDE before use
   function automatic int unsigned side_in_use(input logic [CFG_W-1:0] v);
      if (v < MIN_SIDE) begin
         return MIN_SIDE;
      end
      if (v > SIDE) begin
         return SIDE;
      end
      return v;
   endfunction

   // stores are addressed on the full SIDE pitch, whatever size is in use
   function automatic int unsigned cell_index(input int unsigned c, input int unsigned r);
      return (r * SIDE + c) % CELLS;
   endfunction

   function automatic edge_report_type predict_edge_report(input logic mode,
                                                           input logic [COL_W-1:0] col,
                                                           input logic [ROW_W-1:0] row);
      edge_report_type res;
      int unsigned     w, h, pitch, c, r, at;
      res = '0;
      w   = side_in_use(grid_width_q);
      h   = side_in_use(grid_height_q);
      c   = col;
      r   = row;
      if (mode == MODE_TOGGLE) begin
         // interior cells only; a border cell leaves the stores alone
         if (c < 1 || r < 1 || c >= w - 1 || r >= h - 1) begin
            res.status = STATUS_REJECT;
         end else begin
            top_edge_map[cell_index(c, r)]      ^= 1'b1;
            left_edge_map[cell_index(c, r)]     ^= 1'b1;
            top_edge_map[cell_index(c, r + 1)]  ^= 1'b1;
            left_edge_map[cell_index(c + 1, r)] ^= 1'b1;
         end
      end else if (c >= w || r >= h) begin
         res.status = STATUS_REJECT;
      end else begin
         at    = cell_index(c, r);
         pitch = w + 1;
         res.top_link           = top_edge_map[at];
         res.left_link          = left_edge_map[at];
         res.corner_top_left    = CORNER_W'(r * pitch + c);
         res.corner_top_right   = CORNER_W'(r * pitch + c + 1);
         res.corner_bottom_left = CORNER_W'((r + 1) * pitch + c);
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Monitor: results are checked before the item accepted at the same edge
   // is predicted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      edge_report_type got;
      edge_report_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_GRID_WIDTH) begin
               grid_width_q = csr_wdata;
            end else if (csr_index == REG_GRID_HEIGHT) begin
               grid_height_q = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_top_link, rsp_left_link, rsp_corner_top_left,
                    rsp_corner_top_right, rsp_corner_bottom_left};
            if (pending_reports.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                       results_seen));
            end else begin
               want = pending_reports.pop_front();
               if (got.status !== want.status)
                  flag_mismatch($sformatf("result %0d status %0b, expected %0b",
                                          results_seen, got.status, want.status));
               if (got.top_link !== want.top_link)
                  flag_mismatch($sformatf("result %0d top_link %0b, expected %0b",
                                          results_seen, got.top_link, want.top_link));
               if (got.left_link !== want.left_link)
                  flag_mismatch($sformatf("result %0d left_link %0b, expected %0b",
                                          results_seen, got.left_link, want.left_link));
               if (got.corner_top_left !== want.corner_top_left)
                  flag_mismatch($sformatf("result %0d corner_top_left %0d, expected %0d",
                                          results_seen, got.corner_top_left,
                                          want.corner_top_left));
               if (got.corner_top_right !== want.corner_top_right)
                  flag_mismatch($sformatf("result %0d corner_top_right %0d, expected %0d",
                                          results_seen, got.corner_top_right,
                                          want.corner_top_right));
               if (got.corner_bottom_left !== want.corner_bottom_left)
                  flag_mismatch($sformatf("result %0d corner_bottom_left %0d, expected %0d",
                                          results_seen, got.corner_bottom_left,
                                          want.corner_bottom_left));
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            // the predictor always runs so its edge maps stay in step
            want = predict_edge_report(req_mode, req_col, req_row);
            if (req_typed) begin
               want = req_want;
            end
            pending_reports.push_back(want);
         end
      end
   end

   // Watchdog: any handshake counts as progress. The clearing pass after
   // reset is the longest quiet stretch a correct block shows.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, calm stretches, and the odd long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int  stall;
      int  taken;
      bit  calm;
      taken = 0;
      calm  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
         end
         taken++;
         if (rsp_holds_done < rsp_holds_asked) begin
            stall = LONG_HOLD;
            rsp_holds_done++;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Offers one item after a random gap; returns at the edge it is taken.
   // With no gap, valid simply stays high into the next item.
   task automatic issue_item(input logic mode, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic typed,
                             input edge_report_type want);
      int gap;
      if (items_issued % 40 == 0) begin
         sender_calm = ($urandom_range(0, 2) == 0);
      end
      items_issued++;
      gap = sender_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_col   <= col;
      req_row   <= row;
      req_typed <= typed;
      req_want  <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering and waits for every expected result; at least one edge
   // passes, so valid is never lowered and raised in one step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   // Size registers change only with the block idle.
   task automatic resize_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      grid_width_set  = w;
      grid_height_set = h;
      csr_valid <= 1'b1;
      csr_index <= REG_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-aimed toggles and reports inside the grid in use, with a
   // fifth of raw noise that lands on borders and outside cells.
   task automatic run_random_items(input int count, input int hold_at, input int pause_at);
      int unsigned      w, h;
      int               n, pick;
      logic             mode;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      w = side_in_use(grid_width_set);
      h = side_in_use(grid_height_set);
      for (n = 0; n < count; n++) begin
         if (n == hold_at) begin
            rsp_holds_asked++;
         end
         if (n == pause_at) begin
            drain_results();
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            mode = MODE_TOGGLE;
            col  = COL_W'($urandom_range(1, w - 2));
            row  = ROW_W'($urandom_range(1, h - 2));
         end else if (pick < 80) begin
            mode = MODE_REPORT;
            col  = COL_W'($urandom_range(0, w - 1));
            row  = ROW_W'($urandom_range(0, h - 1));
         end else begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_TOGGLE : MODE_REPORT;
            col  = COL_W'($urandom_range(0, SIDE - 1));
            row  = ROW_W'($urandom_range(0, SIDE - 1));
         end
         issue_item(mode, col, row, 1'b0, '0);
      end
   endtask

   initial begin
      int idx;

      // Directed table at the reset size of 64 x 64. Typed rows: fresh stores
      // read as zero, the corner cells give the extreme indices, border and
      // edge-of-grid toggles are rejected, and a plain interior toggle is
      // done with all fields zero.
      probe_table[0]  = '{MODE_REPORT, 6'd0,  6'd0,  1'b1,
                          '{STATUS_DONE, 1'b0, 1'b0, 13'd0, 13'd1, 13'd65}};
      probe_table[1]  = '{MODE_REPORT, 6'd63, 6'd63, 1'b1,
                          '{STATUS_DONE, 1'b0, 1'b0, 13'd4158, 13'd4159, 13'd4223}};
      probe_table[2]  = '{MODE_REPORT, 6'd63, 6'd0,  1'b1,
                          '{STATUS_DONE, 1'b0, 1'b0, 13'd63, 13'd64, 13'd128}};
      probe_table[3]  = '{MODE_REPORT, 6'd0,  6'd63, 1'b1,
                          '{STATUS_DONE, 1'b0, 1'b0, 13'd4095, 13'd4096, 13'd4160}};
      probe_table[4]  = '{MODE_TOGGLE, 6'd0,  6'd0,  1'b1, '{STATUS_REJECT, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[5]  = '{MODE_TOGGLE, 6'd63, 6'd63, 1'b1, '{STATUS_REJECT, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[6]  = '{MODE_TOGGLE, 6'd0,  6'd5,  1'b1, '{STATUS_REJECT, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[7]  = '{MODE_TOGGLE, 6'd5,  6'd0,  1'b1, '{STATUS_REJECT, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[8]  = '{MODE_TOGGLE, 6'd63, 6'd5,  1'b1, '{STATUS_REJECT, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[9]  = '{MODE_TOGGLE, 6'd5,  6'd63, 1'b1, '{STATUS_REJECT, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[10] = '{MODE_TOGGLE, 6'd62, 6'd62, 1'b1, '{STATUS_DONE, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      probe_table[11] = '{MODE_TOGGLE, 6'd1,  6'd1,  1'b1, '{STATUS_DONE, 1'b0, 1'b0,
                                                             13'd0, 13'd0, 13'd0}};
      // from here on the predictor answers: neighbours sharing an edge,
      // a double toggle that cancels, and alternating bit patterns
      probe_table[12] = '{MODE_REPORT, 6'd1,  6'd1,  1'b0, '0};
      probe_table[13] = '{MODE_REPORT, 6'd2,  6'd1,  1'b0, '0};
      probe_table[14] = '{MODE_REPORT, 6'd1,  6'd2,  1'b0, '0};
      probe_table[15] = '{MODE_TOGGLE, 6'd2,  6'd1,  1'b0, '0};
      probe_table[16] = '{MODE_REPORT, 6'd2,  6'd1,  1'b0, '0};
      probe_table[17] = '{MODE_REPORT, 6'd62, 6'd62, 1'b0, '0};
      probe_table[18] = '{MODE_REPORT, 6'd63, 6'd62, 1'b0, '0};
      probe_table[19] = '{MODE_REPORT, 6'd62, 6'd63, 1'b0, '0};
      probe_table[20] = '{MODE_TOGGLE, 6'd1,  6'd1,  1'b0, '0};
      probe_table[21] = '{MODE_REPORT, 6'd1,  6'd1,  1'b0, '0};
      probe_table[22] = '{MODE_REPORT, 6'd42, 6'd21, 1'b0, '0};
      probe_table[23] = '{MODE_REPORT, 6'd21, 6'd42, 1'b0, '0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // items are offered straight away; the clearing pass holds them off
      for (idx = 0; idx < PROBE_ROWS; idx++) begin
         issue_item(probe_table[idx].mode, probe_table[idx].col, probe_table[idx].row,
                    probe_table[idx].typed, probe_table[idx].want);
      end
      run_random_items(300, -1, -1);

      // smallest grid: a single interior cell
      resize_grid(7'd3, 7'd3);
      run_random_items(200, -1, -1);

      // below and above range, clamped to 3 wide and 64 high; mid-phase the
      // sender waits for every result before going on
      resize_grid(7'd0, 7'd127);
      run_random_items(250, -1, 120);

      resize_grid(7'd127, 7'd2);
      run_random_items(250, -1, -1);

      // small grid over old edges; the receiver holds off so the block backs up
      resize_grid(7'd10, 7'd7);
      run_random_items(300, 100, -1);

      resize_grid(7'd65, 7'd40);
      run_random_items(300, 150, -1);

      resize_grid(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 127)));
      run_random_items(250, -1, -1);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/gfte_pkg.sv
design/gfte_ram.sv
design/grid_face_toggle_edge_store.sv
sim/grid_face_toggle_edge_store_tb.sv
